// ===== sv/sm3_pkg.sv =====
// SM3 hash engine package: constants, round functions and the
// command/status structs shared by the controller and the datapath.
// Depends on nothing.
package sm3_pkg;

    localparam int CvWords = 8;

    typedef logic [31:0] word_t;

    localparam word_t T_LOW  = 32'h79CC4519;
    localparam word_t T_HIGH = 32'h7A879D8A;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] POS_LAST = 6'h3F;
    localparam logic [5:0] POS_LEN  = 6'd56;

    typedef word_t iv_t [CvWords];
    localparam iv_t IV = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // Source of the byte that is shifted into the block buffer.
    typedef logic [1:0] bsel_t;
    localparam bsel_t BSEL_DATA = 2'd0;
    localparam bsel_t BSEL_PAD  = 2'd1;
    localparam bsel_t BSEL_ZERO = 2'd2;
    localparam bsel_t BSEL_LEN  = 2'd3;

    typedef struct packed {
        logic        shift;      // shift one byte into the block buffer
        bsel_t       bsel;
        logic        count_inc;  // message byte: advance the byte count
        logic        load_work;  // copy chaining value into working words
        logic        round_en;   // run one compression round
        logic        cv_fold;    // chaining value ^= working words
        logic        cv_reset;   // back to IV, counts cleared
        logic [2:0]  word_sel;   // digest word on the output
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;         // bytes in the current block
        logic       round_done;  // last round is running
    } status_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic word_t p0(input word_t x);
        return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic word_t p1(input word_t x);
        return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage

// ===== sv/sm3_ctrl.sv =====
// SM3 controller: sequences byte loading, padding, compression and
// digest output. Depends on sm3_pkg.
module sm3_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_byte_valid,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_word_index,
    output logic              m_last_word,
    output sm3_pkg::cmd_t     cmd,
    input  sm3_pkg::status_t  status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD80 = 3'd1;
    localparam logic [2:0] ST_PADZ  = 3'd2;
    localparam logic [2:0] ST_PADL  = 3'd3;
    localparam logic [2:0] ST_COMP  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;
    logic       wrap;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_EMIT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);
    assign accept       = s_valid && s_ready;
    assign wrap         = (status.pos == sm3_pkg::POS_LAST);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.bsel   = sm3_pkg::BSEL_DATA;
        cmd.word_sel = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_byte_valid) begin
                        cmd.shift     = 1'b1;
                        cmd.count_inc = 1'b1;
                    end
                    if (s_byte_valid && wrap) begin
                        cmd.load_work = 1'b1;
                        ret_next   = s_last ? ST_PAD80 : ST_IDLE;
                        state_next = ST_COMP;
                    end else if (s_last) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                cmd.shift = 1'b1;
                cmd.bsel  = sm3_pkg::BSEL_PAD;
                if (wrap) begin
                    cmd.load_work = 1'b1;
                    ret_next   = ST_PADZ;
                    state_next = ST_COMP;
                end else begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (status.pos == sm3_pkg::POS_LEN) begin
                    state_next = ST_PADL;
                end else begin
                    cmd.shift = 1'b1;
                    cmd.bsel  = sm3_pkg::BSEL_ZERO;
                    if (wrap) begin
                        cmd.load_work = 1'b1;
                        ret_next   = ST_PADZ;
                        state_next = ST_COMP;
                    end
                end
            end
            ST_PADL: begin
                cmd.shift = 1'b1;
                cmd.bsel  = sm3_pkg::BSEL_LEN;
                if (wrap) begin
                    cmd.load_work = 1'b1;
                    ret_next   = ST_EMIT;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                cmd.round_en = 1'b1;
                if (status.round_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.cv_fold = 1'b1;
                state_next  = ret_reg;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.cv_reset = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== sv/sm3_datapath.sv =====
// SM3 datapath: block buffer and message expansion window, byte count,
// working words with the round logic, and the chaining value.
// Depends on sm3_pkg.
module sm3_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_data_byte,
    input  sm3_pkg::cmd_t     cmd,
    output sm3_pkg::status_t  status,
    output logic [31:0]       m_digest_word
);

    // The 512-bit buffer takes bytes at the low end; once full, word 0 sits
    // at the top and it serves as the sixteen-word expansion window.
    logic [511:0]   buf_reg;
    logic [60:0]    count_reg;
    logic [5:0]     pos_reg;
    logic [5:0]     round_reg;
    sm3_pkg::word_t cv_reg [sm3_pkg::CvWords];
    sm3_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;

    logic [63:0]    bit_len;
    logic [7:0]     len_byte;
    logic [7:0]     byte_in;
    sm3_pkg::word_t w0, w3, w4, w7, w10, w13, w_new;
    sm3_pkg::word_t tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
    logic           early;

    assign status.pos        = pos_reg;
    assign status.round_done = (round_reg == 6'd63);
    assign m_digest_word     = cv_reg[cmd.word_sel];

    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = bit_len[6'd63 - {pos_reg[2:0], 3'b000} -: 8];

    always_comb begin
        case (cmd.bsel)
            sm3_pkg::BSEL_DATA: byte_in = s_data_byte;
            sm3_pkg::BSEL_PAD:  byte_in = sm3_pkg::PAD_BYTE;
            sm3_pkg::BSEL_ZERO: byte_in = 8'h00;
            default:            byte_in = len_byte;
        endcase
    end

    assign w0  = buf_reg[511:480];
    assign w3  = buf_reg[415:384];
    assign w4  = buf_reg[383:352];
    assign w7  = buf_reg[287:256];
    assign w10 = buf_reg[191:160];
    assign w13 = buf_reg[95:64];
    assign w_new = sm3_pkg::p1(w0 ^ w7 ^ sm3_pkg::rotl(w13, 5'd15))
                 ^ sm3_pkg::rotl(w3, 5'd7) ^ w10;

    assign early = (round_reg < 6'd16);
    assign tj    = sm3_pkg::rotl(early ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, round_reg[4:0]);
    assign a12   = sm3_pkg::rotl(a_reg, 5'd12);
    assign ss1   = sm3_pkg::rotl(a12 + e_reg + tj, 5'd7);
    assign ss2   = ss1 ^ a12;
    assign ffv   = early ? (a_reg ^ b_reg ^ c_reg)
                         : ((a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg));
    assign ggv   = early ? (e_reg ^ f_reg ^ g_reg)
                         : ((e_reg & f_reg) | (~e_reg & g_reg));
    assign tt1   = ffv + d_reg + ss2 + (w0 ^ w4);
    assign tt2   = ggv + h_reg + ss1 + w0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            round_reg <= '0;
            for (int i = 0; i < sm3_pkg::CvWords; i++) begin
                cv_reg[i] <= sm3_pkg::IV[i];
            end
        end else begin
            if (cmd.shift) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.load_work) begin
                round_reg <= '0;
            end else if (cmd.round_en) begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.cv_fold) begin
                cv_reg[0] <= cv_reg[0] ^ a_reg;
                cv_reg[1] <= cv_reg[1] ^ b_reg;
                cv_reg[2] <= cv_reg[2] ^ c_reg;
                cv_reg[3] <= cv_reg[3] ^ d_reg;
                cv_reg[4] <= cv_reg[4] ^ e_reg;
                cv_reg[5] <= cv_reg[5] ^ f_reg;
                cv_reg[6] <= cv_reg[6] ^ g_reg;
                cv_reg[7] <= cv_reg[7] ^ h_reg;
            end else if (cmd.cv_reset) begin
                for (int i = 0; i < sm3_pkg::CvWords; i++) begin
                    cv_reg[i] <= sm3_pkg::IV[i];
                end
                count_reg <= '0;
                pos_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            buf_reg <= {buf_reg[503:0], byte_in};
        end else if (cmd.round_en) begin
            buf_reg <= {buf_reg[479:0], w_new};
        end
        if (cmd.load_work) begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
            f_reg <= cv_reg[5];
            g_reg <= cv_reg[6];
            h_reg <= cv_reg[7];
        end else if (cmd.round_en) begin
            d_reg <= c_reg;
            c_reg <= {b_reg[22:0], b_reg[31:23]};
            b_reg <= a_reg;
            a_reg <= tt1;
            h_reg <= g_reg;
            g_reg <= {f_reg[12:0], f_reg[31:13]};
            f_reg <= e_reg;
            e_reg <= sm3_pkg::p0(tt2);
        end
    end

endmodule

// ===== sv/sm3_hash_engine.sv =====
// SM3 hash engine, one message byte per item, taken while s_ready is high during loading;
// s_ready drops while each 64-byte block runs 64 rounds in the single round unit and one fold.
// On a last item, padding shifts one byte per cycle up to the block end, pausing for
// one or two compressions, then eight digest words go out, one per accepted item.
// Reset (aresetn, synchronous, active low) loads the IV and clears the byte count.
// Top level: joins sm3_ctrl and sm3_datapath; depends on sm3_pkg.
module sm3_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sm3_pkg::cmd_t    cmd;
    sm3_pkg::status_t status;

    sm3_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .cmd          (cmd),
        .status       (status)
    );

    sm3_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .cmd           (cmd),
        .status        (status),
        .m_digest_word (m_digest_word)
    );

endmodule

// ===== sv/sm3_checker.sv =====
// Port-level checks for sm3_hash_engine, attached with a bind statement.
// Depends only on the top-level ports.
module sm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);

    // No new item is taken while a digest is going out.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest is being emitted");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
        else $error("last_word flag does not match word index");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
            (m_valid && (m_word_index == $past(m_word_index) + 3'd1)))
        else $error("digest words not emitted in order");

    a_end_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (!m_valid && s_ready))
        else $error("engine did not return to idle after the digest");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_word)))
        else $error("result item changed while stalled");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);
